// ----- src/rder_pkg.sv -----
// Shared constants and types for the rotary/tone extension ringer.
// Used by rotary_dtmf_extension_ringer_unit and its testbench; depends on nothing else.
`default_nettype none

package rder_pkg;

	// Number of extensions that have a buzzer line, and the width of the line bus.
	localparam int NUM_EXTENSIONS = 8;
	localparam int LINE_W         = 8;

	// Widths of the configuration port.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Timing constants in milliseconds.
	localparam int UPTIME_STOP   = 10000;
	localparam int SECOND_MSECS  = 1000;
	localparam int LED_ON1_END   = 150;
	localparam int LED_ON2_START = 300;
	localparam int LED_ON2_END   = 450;

	// Register values after reset.
	localparam logic [9:0]  TICK_RST    = 10'd2;
	localparam logic [15:0] GAP_RST     = 16'd200;
	localparam logic [15:0] BUZZ_RST    = 16'd800;
	localparam logic [13:0] STARTUP_RST = 14'd500;
	localparam logic [4:0]  INT_MAX_RST = 5'd15;
	localparam logic [4:0]  RISE_RST    = 5'd10;
	localparam logic [4:0]  FALL_RST    = 5'd4;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TICK_MSECS,
		REG_GAP_LIMIT_MSECS,
		REG_BUZZ_TIME_MSECS,
		REG_STARTUP_WAIT_MSECS,
		REG_INTEGRATOR_MAX,
		REG_RISE_LEVEL,
		REG_FALL_LEVEL
	} cfg_reg_t;

	// Where the reported digit came from.
	typedef enum logic [1:0] {
		SRC_NONE   = 2'd0,
		SRC_TONE   = 2'd1,
		SRC_ROTARY = 2'd2
	} digit_src_t;

endpackage

`default_nettype wire

// ----- src/rotary_dtmf_extension_ringer_unit.sv -----
// Top level of the rotary/tone extension ringer: debounce, pulse counting,
// buzzer line drive and heartbeat LED. Depends on rder_pkg.
`default_nettype none

// One input word is one loop tick. The block takes a word in every cycle
// in which the input side is not stalled.
// The word is captured in an input register. The whole tick update (LED
// fraction, tone selection, integrator, dial sequencer, buzz timer and phase
// counter) is one combinational pass from that register and the state
// registers, and the result lands in an output register. The sustained rate is
// one word per cycle while the output side takes words. A waiting result still
// lets one more word into the input register, and the input side stalls only
// while both registers are full. There is no clearing pass after reset.
module rotary_dtmf_extension_ringer_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [rder_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [rder_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Tick input stream
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	input  wire logic [7:0]                        s_tdata,  // raw_pulse[0], tone_code[4:1], zero
	input  wire logic                              s_tuser,  // tone_strobe[0]
	// Result stream
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	output      logic [15:0]                       m_tdata,  // buzzer_lines[7:0],
	                                                         // selected_digit[11:8],
	                                                         // status_led[12], zero
	output      logic [1:0]                        m_tuser   // digit_source[1:0]
);
	import rder_pkg::*;

	typedef enum logic [1:0] {
		DIAL_IDLE,
		DIAL_PULSE,
		DIAL_SPACE,
		DIAL_DONE
	} dial_mode_t;

	// Configuration registers
	logic [9:0]  tick_q;
	logic [15:0] gap_q;
	logic [15:0] buzz_time_q;
	logic [13:0] startup_q;
	logic [4:0]  int_max_q;
	logic [4:0]  rise_q;
	logic [4:0]  fall_q;

	// Tick state
	logic [4:0]  level_q;
	logic        clean_q;
	dial_mode_t  mode_q;
	logic [3:0]  count_q;
	logic [15:0] high_q;
	logic [15:0] low_q;
	logic [15:0] buzz_q;
	logic [13:0] uptime_q;
	logic [1:0]  phase_q;
	logic [9:0]  fraction_q;

	// Input register
	logic        valid_s1;
	logic        raw_s1;
	logic        strobe_s1;
	logic [3:0]  code_s1;

	// Output register
	logic        valid_s2;
	logic [7:0]  lines_s2;
	logic [3:0]  digit_s2;
	digit_src_t  src_s2;
	logic        led_s2;

	// Next-state values of one tick
	logic [10:0] frac_sum;
	logic [9:0]  frac_n;
	logic        led_n;
	logic        tone_hit;
	logic        rot_run;
	logic [4:0]  level_n;
	logic        clean_n;
	dial_mode_t  mode_n;
	logic [3:0]  count_n;
	logic [15:0] high_n;
	logic [15:0] low_n;
	logic [15:0] buzz_n;
	logic [1:0]  phase_n;
	logic [1:0]  phase_drv;
	logic [16:0] high_sum;
	logic [16:0] off_sum;
	logic [3:0]  rot_digit;
	logic [3:0]  digit_n;
	digit_src_t  src_n;
	logic [7:0]  lines_n;
	logic [13:0] uptime_n;
	logic [14:0] uptime_sum;

	logic        advance;
	logic        fire;
	logic        s_accept;

	// Handshake: the input register moves on whenever the output register is free.
	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	// Millisecond-within-second counter and heartbeat LED.
	always_comb begin
		frac_sum = {1'b0, fraction_q} + {1'b0, tick_q};
		if (frac_sum >= 11'(2 * SECOND_MSECS)) begin
			frac_n = 10'(frac_sum - 11'(2 * SECOND_MSECS));
		end else if (frac_sum >= 11'(SECOND_MSECS)) begin
			frac_n = 10'(frac_sum - 11'(SECOND_MSECS));
		end else begin
			frac_n = frac_sum[9:0];
		end
		led_n = (frac_n <= 10'(LED_ON1_END))
			|| ((frac_n >= 10'(LED_ON2_START)) && (frac_n <= 10'(LED_ON2_END)));
	end

	// A tone key with a nonzero code wins; otherwise the rotary path runs once the
	// power-up wait is over.
	assign tone_hit = strobe_s1 && (code_s1 != 4'd0);
	assign rot_run  = !tone_hit && (uptime_q >= startup_q);

	// Rotary path: integrator, dial sequencer and buzz timer.
	always_comb begin
		level_n   = level_q;
		clean_n   = clean_q;
		mode_n    = mode_q;
		count_n   = count_q;
		high_n    = high_q;
		low_n     = low_q;
		buzz_n    = buzz_q;
		phase_n   = phase_q;
		high_sum  = '0;
		off_sum   = '0;
		rot_digit = '0;
		if (rot_run) begin
			// Saturating integrator with hysteresis; rise is tested first.
			if (raw_s1) begin
				level_n = (level_q < int_max_q) ? level_q + 5'd1 : int_max_q;
			end else if (level_q != 5'd0) begin
				level_n = level_q - 5'd1;
			end
			if (level_n >= rise_q) begin
				clean_n = 1'b1;
			end else if (level_n <= fall_q) begin
				clean_n = 1'b0;
			end

			if (clean_n) begin
				// A pulse after idle or a finished digit starts a new sequence.
				if (mode_q == DIAL_IDLE || mode_q == DIAL_DONE) begin
					count_n = '0;
					high_n  = '0;
					buzz_n  = '0;
					phase_n = phase_q + 2'd1;
				end
				mode_n   = DIAL_PULSE;
				low_n    = '0;
				high_sum = {1'b0, high_n} + {7'b0, tick_q};
				high_n   = high_sum[16] ? 16'hFFFF : high_sum[15:0];
			end else if (mode_q == DIAL_PULSE || mode_q == DIAL_SPACE) begin
				// Falling edge of a pulse counts it; a long gap ends the digit.
				mode_n = DIAL_SPACE;
				if (high_q != 16'd0) begin
					high_n = '0;
					if (count_q != 4'hF) begin
						count_n = count_q + 4'd1;
					end
				end
				off_sum = {1'b0, low_q} + {7'b0, tick_q};
				low_n   = off_sum[16] ? 16'hFFFF : off_sum[15:0];
				if (off_sum > {1'b0, gap_q}) begin
					mode_n = DIAL_DONE;
					buzz_n = buzz_time_q;
				end
			end

			// Hold the finished digit for the buzz time, then clear the sequence.
			if (mode_n == DIAL_DONE && buzz_n != 16'd0) begin
				if (buzz_n <= {6'b0, tick_q}) begin
					mode_n  = DIAL_IDLE;
					count_n = '0;
					high_n  = '0;
					low_n   = '0;
					buzz_n  = '0;
					phase_n = phase_n + 2'd1;
				end else begin
					buzz_n    = buzz_n - {6'b0, tick_q};
					rot_digit = count_n;
				end
			end
		end
	end

	// Digit selection and buzzer line drive.
	always_comb begin
		if (tone_hit) begin
			digit_n = code_s1;
			src_n   = SRC_TONE;
		end else begin
			digit_n = rot_digit;
			src_n   = (rot_digit != 4'd0) ? SRC_ROTARY : SRC_NONE;
		end
		// The drive stage steps the phase once per tick; line toggles from its top bit.
		phase_drv = phase_n + 2'd1;
		if (digit_n >= 4'd1 && digit_n <= 4'(NUM_EXTENSIONS) && digit_n <= 4'(LINE_W)) begin
			lines_n = LINE_W'(phase_drv[1]) << (digit_n - 4'd1);
		end else begin
			lines_n = '0;
		end
	end

	// Uptime counts until it reaches its stop value.
	always_comb begin
		uptime_sum = {1'b0, uptime_q} + {5'b0, tick_q};
		uptime_n   = (uptime_q < 14'(UPTIME_STOP)) ? uptime_sum[13:0] : uptime_q;
	end

	// Configuration, state, input and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= TICK_RST;
			gap_q       <= GAP_RST;
			buzz_time_q <= BUZZ_RST;
			startup_q   <= STARTUP_RST;
			int_max_q   <= INT_MAX_RST;
			rise_q      <= RISE_RST;
			fall_q      <= FALL_RST;
			level_q     <= '0;
			clean_q     <= 1'b0;
			mode_q      <= DIAL_IDLE;
			count_q     <= '0;
			high_q      <= '0;
			low_q       <= '0;
			buzz_q      <= '0;
			uptime_q    <= '0;
			phase_q     <= '0;
			fraction_q  <= '0;
			valid_s1    <= 1'b0;
			raw_s1      <= 1'b0;
			strobe_s1   <= 1'b0;
			code_s1     <= '0;
			valid_s2    <= 1'b0;
			lines_s2    <= '0;
			digit_s2    <= '0;
			src_s2      <= SRC_NONE;
			led_s2      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TICK_MSECS:         tick_q      <= cfg_data[9:0];
					REG_GAP_LIMIT_MSECS:    gap_q       <= cfg_data;
					REG_BUZZ_TIME_MSECS:    buzz_time_q <= cfg_data;
					REG_STARTUP_WAIT_MSECS: startup_q   <= cfg_data[13:0];
					REG_INTEGRATOR_MAX:     int_max_q   <= cfg_data[4:0];
					REG_RISE_LEVEL:         rise_q      <= cfg_data[4:0];
					REG_FALL_LEVEL:         fall_q      <= cfg_data[4:0];
					default: ;
				endcase
			end

			if (s_accept) begin
				valid_s1  <= 1'b1;
				raw_s1    <= s_tdata[0];
				strobe_s1 <= s_tuser;
				code_s1   <= s_tdata[4:1];
			end else if (advance) begin
				valid_s1  <= 1'b0;
			end

			if (advance) begin
				valid_s2 <= valid_s1;
			end

			if (fire) begin
				level_q    <= level_n;
				clean_q    <= clean_n;
				mode_q     <= mode_n;
				count_q    <= count_n;
				high_q     <= high_n;
				low_q      <= low_n;
				buzz_q     <= buzz_n;
				uptime_q   <= uptime_n;
				phase_q    <= phase_drv;
				fraction_q <= frac_n;
				digit_s2   <= digit_n;
				src_s2     <= src_n;
				led_s2     <= led_n;
				lines_s2   <= lines_n;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, led_s2, digit_s2, lines_s2};
	assign m_tuser  = src_s2;

`ifndef SYNTHESIS
	// An idle dial sequencer has no leftover count or timers.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == DIAL_IDLE) |-> (count_q == 4'd0 && high_q == 16'd0
			&& low_q == 16'd0 && buzz_q == 16'd0))
		else $error("dial idle with stale counters");

	// While a pulse is on the gap timer is held at zero, and in a gap the on-time is.
	a_pulse_low: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == DIAL_PULSE) |-> (low_q == 16'd0))
		else $error("gap time running during pulse");
	a_space_high: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == DIAL_SPACE) |-> (high_q == 16'd0))
		else $error("on-time left over in gap");

	// The fraction of a second always stays below one second.
	a_fraction: assert property (@(posedge clk) disable iff (!arst_n)
		fraction_q < 10'(SECOND_MSECS))
		else $error("second fraction out of range");

	// Every processed tick steps the buzzer phase.
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (phase_q != $past(phase_q)))
		else $error("phase did not step");

	// An empty output register never blocks the input side.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with free output register");
`endif

endmodule

`default_nettype wire

// ----- dv/rotary_dtmf_extension_ringer_unit_test.sv -----
// Self-checking testbench for rotary_dtmf_extension_ringer_unit: tone and dial
// stimulus, a scoreboard that predicts every result word, and a watchdog.
// Depends on rder_pkg and the unit itself.

module rotary_dtmf_extension_ringer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rder_pkg::*;

	// Cycles without any accepted word before the run is declared hung.
	localparam int IDLE_LIMIT = 2000;

	typedef enum bit [1:0] {
		DIAL_IDLE,
		DIAL_PULSE,
		DIAL_SPACE,
		DIAL_DONE
	} dial_state_t;

	// Fields of one result word.
	typedef struct {
		bit [7:0]   lines;
		bit [3:0]   digit;
		digit_src_t source;
		bit         led;
	} tick_result_t;

	// Tracks the ringer's configuration and state, and holds the result words
	// still owed by the block.
	class ringer_scoreboard;
		bit [9:0]    tick_ms;
		bit [15:0]   gap_ms;
		bit [15:0]   buzz_ms;
		bit [13:0]   startup_ms;
		bit [4:0]    int_max;
		bit [4:0]    rise_lvl;
		bit [4:0]    fall_lvl;

		bit [4:0]    level;
		bit          pulse_on;
		dial_state_t dial;
		bit [3:0]    pulses;
		bit [15:0]   on_ms;
		bit [15:0]   off_ms;
		bit [15:0]   buzz_left;
		bit [13:0]   uptime;
		bit [1:0]    phase;
		bit [9:0]    ms_in_sec;

		tick_result_t owed_words[$];
		int unsigned  errors;
		int unsigned  words_seen;

		function new();
			tick_ms    = TICK_RST;
			gap_ms     = GAP_RST;
			buzz_ms    = BUZZ_RST;
			startup_ms = STARTUP_RST;
			int_max    = INT_MAX_RST;
			rise_lvl   = RISE_RST;
			fall_lvl   = FALL_RST;
			level      = '0;
			pulse_on   = 1'b0;
			dial       = DIAL_IDLE;
			pulses     = '0;
			on_ms      = '0;
			off_ms     = '0;
			buzz_left  = '0;
			uptime     = '0;
			phase      = '0;
			ms_in_sec  = '0;
			errors     = 0;
			words_seen = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, bit [15:0] value);
			case (idx)
				REG_TICK_MSECS:         tick_ms    = value[9:0];
				REG_GAP_LIMIT_MSECS:    gap_ms     = value;
				REG_BUZZ_TIME_MSECS:    buzz_ms    = value;
				REG_STARTUP_WAIT_MSECS: startup_ms = value[13:0];
				REG_INTEGRATOR_MAX:     int_max    = value[4:0];
				REG_RISE_LEVEL:         rise_lvl   = value[4:0];
				REG_FALL_LEVEL:         fall_lvl   = value[4:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return owed_words.size();
		endfunction

		function bit [15:0] clip16(int unsigned value);
			return (value > 32'hFFFF) ? 16'hFFFF : value[15:0];
		endfunction

		// A fresh dialling sequence or an expired buzz clears the dial and
		// advances the buzzer phase by one step.
		function void restart_dial();
			dial      = DIAL_IDLE;
			pulses    = '0;
			on_ms     = '0;
			off_ms    = '0;
			buzz_left = '0;
			phase     = phase + 2'd1;
		endfunction

		// Saturating integrator; the rise threshold wins when the two overlap.
		function bit debounce(bit raw);
			if (raw) begin
				level = (level < int_max) ? level + 5'd1 : int_max;
			end else if (level != 0) begin
				level = level - 5'd1;
			end
			if (level >= rise_lvl) begin
				pulse_on = 1'b1;
			end else if (level <= fall_lvl) begin
				pulse_on = 1'b0;
			end
			return pulse_on;
		endfunction

		// Pulse counting: each completed pulse adds one, a long enough gap
		// closes the digit and loads the buzz time.
		function void advance_dial(bit raw);
			bit          on;
			int unsigned gap_sum;
			on = debounce(raw);
			if (!on && (dial == DIAL_IDLE || dial == DIAL_DONE))
				return;
			if (on) begin
				if (dial == DIAL_IDLE || dial == DIAL_DONE)
					restart_dial();
				dial   = DIAL_PULSE;
				off_ms = '0;
				on_ms  = clip16(32'(on_ms) + 32'(tick_ms));
			end else begin
				dial = DIAL_SPACE;
				if (on_ms != 0) begin
					on_ms = '0;
					if (pulses != 4'hF)
						pulses = pulses + 4'd1;
				end
				// The unclipped sum decides whether the gap is long enough.
				gap_sum = 32'(off_ms) + 32'(tick_ms);
				off_ms  = clip16(gap_sum);
				if (gap_sum > 32'(gap_ms)) begin
					dial      = DIAL_DONE;
					buzz_left = buzz_ms;
				end
			end
		endfunction

		function bit [3:0] rotary_digit(bit raw);
			if (uptime < startup_ms)
				return 4'd0;
			advance_dial(raw);
			if (dial == DIAL_DONE && buzz_left != 0) begin
				if (buzz_left <= tick_ms) begin
					restart_dial();
				end else begin
					buzz_left = buzz_left - tick_ms;
					return pulses;
				end
			end
			return 4'd0;
		endfunction

		// Works out the result word of one accepted tick.
		function void note_tick(bit raw, bit strobe, bit [3:0] code);
			tick_result_t want;
			int unsigned  frac;
			frac      = (32'(ms_in_sec) + 32'(tick_ms)) % SECOND_MSECS;
			ms_in_sec = frac[9:0];
			want.led  = (frac <= LED_ON1_END) ||
			            (frac >= LED_ON2_START && frac <= LED_ON2_END);

			// A held key with a real code overrides the dial for this tick.
			if (strobe && code != 0) begin
				want.digit  = code;
				want.source = SRC_TONE;
			end else begin
				want.digit  = rotary_digit(raw);
				want.source = (want.digit != 0) ? SRC_ROTARY : SRC_NONE;
			end

			phase      = phase + 2'd1;
			want.lines = '0;
			if (want.digit >= 1 && want.digit <= NUM_EXTENSIONS && want.digit <= LINE_W)
				want.lines[want.digit - 1] = phase[1];

			if (uptime < UPTIME_STOP)
				uptime = uptime + tick_ms;
			owed_words.push_back(want);
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			errors++;
			$display("mismatch on %s in result word %0d: got %0h, expected %0h",
			         what, words_seen, got, want);
		endtask

		task check_word(logic [15:0] data, logic [1:0] user);
			tick_result_t want;
			words_seen++;
			if (owed_words.size() == 0) begin
				report("unexpected result word", data, 16'h0);
				return;
			end
			want = owed_words.pop_front();
			if (data[7:0] !== want.lines)
				report("buzzer_lines", 16'(data[7:0]), 16'(want.lines));
			if (data[11:8] !== want.digit)
				report("selected_digit", 16'(data[11:8]), 16'(want.digit));
			if (data[12] !== want.led)
				report("status_led", 16'(data[12]), 16'(want.led));
			if (user !== want.source)
				report("digit_source", 16'(user), 16'(want.source));
		endtask

		task flag_leftovers();
			if (owed_words.size() != 0)
				report("words never delivered", 16'(owed_words.size()), 16'h0);
		endtask
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	cfg_reg_t    cfg_index = REG_TICK_MSECS;
	logic [15:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	ringer_scoreboard board;
	int unsigned      send_idle_pct  = 0;
	int unsigned      recv_stall_pct = 0;
	int unsigned      ticks_sent     = 0;
	int unsigned      quiet_cycles   = 0;

	rotary_dtmf_extension_ringer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // raw_pulse[0], tone_code[4:1], zero
		.s_tuser  (s_tuser),   // tone_strobe[0]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // buzzer_lines[7:0], selected_digit[11:8], status_led[12]
		.m_tuser  (m_tuser)    // digit_source[1:0]
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Every accepted tick word is handed to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			board.note_tick(s_tdata[0], s_tuser, s_tdata[4:1]);
	end

	// Every accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_word(m_tdata, m_tuser);
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Watchdog: too long without any word moving on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offers one tick word and returns at the falling edge after it is taken.
	// Valid is left high so that back-to-back words need no second assignment.
	task automatic send_tick(bit raw, bit strobe, bit [3:0] code);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, code, raw};
		s_tuser  <= strobe;
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
		@(negedge clk);
	endtask

	// Holds the tick stream and waits until every owed result has arrived.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (board.pending() != 0);
	endtask

	task automatic write_reg(cfg_reg_t idx, bit [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		board.set_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic write_settings(bit [15:0] tick, bit [15:0] gap, bit [15:0] buzz,
	                              bit [15:0] startup, bit [15:0] imax,
	                              bit [15:0] rise_lv, bit [15:0] fall_lv);
		write_reg(REG_TICK_MSECS, tick);
		write_reg(REG_GAP_LIMIT_MSECS, gap);
		write_reg(REG_BUZZ_TIME_MSECS, buzz);
		write_reg(REG_STARTUP_WAIT_MSECS, startup);
		write_reg(REG_INTEGRATOR_MAX, imax);
		write_reg(REG_RISE_LEVEL, rise_lv);
		write_reg(REG_FALL_LEVEL, fall_lv);
		cfg_we <= 1'b0;
	endtask

	// A fixed dial line level for a number of ticks, no key held.
	task automatic hold_raw(bit raw, int unsigned count);
		repeat (count) send_tick(raw, 1'b0, 4'($urandom));
	endtask

	// One dial tick, with an optional flipped sample and a rare key press.
	task automatic rotary_tick(bit line, int unsigned noise_pct);
		send_tick(line ^ ($urandom_range(0, 99) < noise_pct),
		          $urandom_range(0, 99) < 2, 4'($urandom));
	endtask

	// A dialled digit shaped from the current thresholds and timers, so that
	// pulses clear the integrator and the gap completes the digit. A broken
	// one uses glitch-length pulses and stops short.
	task automatic dial_digit(int unsigned noise_pct, bit broken);
		int unsigned count, hi, lo, tail;
		count = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 12);
		hi    = board.rise_lvl + 1 + $urandom_range(0, 2);
		lo    = ((board.int_max > board.fall_lvl) ? board.int_max - board.fall_lvl : 0)
		        + 1 + $urandom_range(0, 2);
		if (board.tick_ms == 0)
			tail = $urandom_range(4, 20);
		else
			tail = board.gap_ms / board.tick_ms + board.int_max + 2
			       + $urandom_range(0, board.buzz_ms / board.tick_ms + 2);
		if (tail > 150)
			tail = 150;
		if (broken) begin
			hi   = $urandom_range(1, hi);
			lo   = $urandom_range(1, lo + 4);
			tail = $urandom_range(0, 3);
		end
		repeat (count) begin
			repeat (hi) rotary_tick(1'b1, noise_pct);
			repeat (lo) rotary_tick(1'b0, noise_pct);
		end
		repeat (tail) rotary_tick(1'b0, noise_pct);
	endtask

	// Mostly clean dialling, with noisy and broken digits, key presses and
	// random words mixed in; now and then the sender waits for the results.
	task automatic run_phase(int unsigned budget);
		int unsigned first, pick;
		bit [3:0]    code;
		first = ticks_sent;
		while (ticks_sent - first < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				dial_digit(0, 1'b0);
			end else if (pick < 70) begin
				dial_digit(8, 1'b0);
			end else if (pick < 78) begin
				dial_digit(0, 1'b1);
			end else if (pick < 90) begin
				code = 4'($urandom);
				repeat ($urandom_range(1, 6)) send_tick(1'($urandom), 1'b1, code);
			end else begin
				repeat ($urandom_range(1, 8))
					send_tick(1'($urandom), 1'($urandom), 4'($urandom));
			end
			if ($urandom_range(0, 99) < 4)
				drain();
		end
	endtask

	initial begin
		board = new();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: the dial is still in its power-up wait, so only
		// key presses select. All codes, a strobe with code zero, and codes
		// with no strobe.
		for (int c = 1; c < 16; c++)
			send_tick(1'b0, 1'b1, 4'(c));
		send_tick(1'b1, 1'b1, 4'h0);
		send_tick(1'b1, 1'b0, 4'hF);
		send_tick(1'b0, 1'b0, 4'h0);
		send_tick(1'b1, 1'b1, 4'hF);
		send_tick(1'b0, 1'b1, 4'h8);
		drain();

		// Quick dialling with a narrow integrator.
		write_settings(10, 60, 100, 0, 4, 3, 1);
		run_phase(60);
		drain();

		// Overlapping thresholds; sender idles.
		send_idle_pct = 59;
		write_settings(5, 25, 40, 300, 8, 2, 5);
		run_phase(50);
		drain();

		// No gap allowance and no buzz time; receiver stalls.
		send_idle_pct  = 0;
		recv_stall_pct = 59;
		write_settings(1, 0, 0, 0, 1, 1, 0);
		run_phase(40);
		drain();

		// Largest timers: power-up wait at the uptime ceiling, pulse count,
		// on time and off time all driven into saturation.
		send_idle_pct  = 26;
		recv_stall_pct = 26;
		write_settings(1000, 16'hFFFF, 16'hFFFF, 10000, 1, 1, 0);
		hold_raw(1'b0, 12);
		repeat (17) begin
			hold_raw(1'b1, 1);
			hold_raw(1'b0, 1);
		end
		hold_raw(1'b1, 70);
		hold_raw(1'b0, 140);
		drain();

		// Zero tick with the widest integrator; ends mid-pulse so the next
		// settings see a pulse that never accumulated any on time.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_settings(0, 10, 10, 0, 31, 31, 31);
		hold_raw(1'b0, 10);
		hold_raw(1'b1, 40);
		drain();

		// Integrator left above the new ceiling; both sides idle.
		send_idle_pct  = 26;
		recv_stall_pct = 26;
		write_settings(2, 20, 30, 0, 6, 4, 2);
		run_phase(50);
		drain();

		// Power-up wait beyond any uptime: the dial never runs.
		send_idle_pct  = 59;
		recv_stall_pct = 0;
		write_settings(50, 100, 100, 14'h3FFF, 31, 0, 31);
		run_phase(20);
		drain();

		// Zero rise level keeps the cleaned pulse on.
		send_idle_pct  = 0;
		recv_stall_pct = 59;
		write_settings(20, 100, 200, 0, 3, 0, 0);
		run_phase(15);
		drain();

		// Moderate settings, no idling.
		recv_stall_pct = 0;
		write_settings(4, 40, 60, 0, 5, 3, 1);
		run_phase(25);
		drain();

		repeat (10) @(negedge clk);
		board.flag_leftovers();
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
src/rder_pkg.sv
src/rotary_dtmf_extension_ringer_unit.sv
dv/rotary_dtmf_extension_ringer_unit_test.sv
